>>> src/sda_pkg.sv
package sda_pkg;

   // Field and state widths
   localparam int SITE_W      = 64;
   localparam int N_W         = 7;
   localparam int MIN_SAMPLES = 2;
   localparam int MAX_SAMPLES = 64;
   localparam int HET_W       = 27;
   localparam int SQ_W        = 29;
   localparam int POLY_W      = 17;
   localparam int PI_W        = 32;
   localparam int TH_W        = 34;
   localparam int DIFF_W      = 35;
   localparam int RSP_W       = 120;

   // Shared multiplier and divider widths
   localparam int PROD_W  = 2 * N_W;
   localparam int DEN_W   = 12;
   localparam int SCALE_SH = 17;
   localparam int DIV_W   = SQ_W + SCALE_SH;
   localparam int DCNT_W  = $clog2(DIV_W);

   // Popcount slice taken per cycle
   localparam int CHUNK_W  = 8;
   localparam int CHUNKS   = SITE_W / CHUNK_W;
   localparam int STEP_W   = $clog2(CHUNKS);
   localparam int PCNT_W   = $clog2(CHUNK_W + 1);

   // Divider handshake
   typedef struct packed {
      logic start;
   } div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

>>> src/sda_divider.sv
module sda_divider import sda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  div_ctrl_type       ctrl,
   input  logic [DIV_W-1:0]   dividend,
   input  logic [DEN_W-1:0]   divisor,
   output div_stat_type       stat,
   output logic [DIV_W-1:0]   quotient
);

   logic               busy_ff;
   logic               done_ff;
   logic [DCNT_W-1:0]  cnt_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DIV_W-1:0]   quo_ff;

   logic [DEN_W:0]     trial;
   logic               fits;
   logic [DEN_W-1:0]   rem_in;

   // Restoring step: bring down one dividend bit, subtract when it fits
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      fits   = (trial >= {1'b0, den_ff});
      rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
   end

   // Advance one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            den_ff  <= divisor;
            rem_ff  <= '0;
            quo_ff  <= dividend;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            quo_ff <= {quo_ff[DIV_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

>>> src/site_diversity_accumulator.sv
// Site diversity accumulator. Each word on req_ carries one site column
// (bit i set when haplotype i carries the derived allele); the allele count c
// is taken over the lowest n_samples bits, with n_samples clamped to 2..64.
// Per site the block adds c*(n-c) and c*c into saturating sums and counts the
// sites with 0<c<n. A word with req_tlast set is accumulated, then one rsp_
// word is produced holding pi and theta_H in Q16 (truncated, saturated),
// their difference pi - theta_H and the segregating-site count, and the sums
// are cleared. Per site: the word is accepted, the column is popcounted at one
// byte per cycle, then c*(n-c) and c*c are formed on the shared 7x7 multiplier;
// a last site then forms n*(n-1) and runs the shared restoring divider, which
// produces one quotient bit per cycle, twice (46 bits each), and loads the
// result once the output register is free.
// req_tready is low while a site is in work. A finished result sits in the
// output register until taken, and the next site may be accepted meanwhile.
// Write csr_wr_data only while the block is idle.
module site_diversity_accumulator import sda_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // Configuration: n_samples
   input  logic             csr_wr_en,
   input  logic [N_W-1:0]   csr_wr_data,
   // Site input
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [63:0]      req_tdata,   // [63:0] site_bits
   input  logic             req_tlast,   // last_site
   // Result output
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // [31:0] pi_q16, [65:32] theta_h_q16,
                                         // [100:66] h_diff_q16, [117:101] seg_sites
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_MAC,
      ST_START_HET,
      ST_WAIT_HET,
      ST_START_SQ,
      ST_WAIT_SQ,
      ST_OUT
   } state_type;

   localparam logic [1:0] PH_HET = 2'd0;
   localparam logic [1:0] PH_SQ  = 2'd1;
   localparam logic [1:0] PH_DEN = 2'd2;

   state_type           state_ff;
   logic [N_W-1:0]      n_samples_ff;
   logic [SITE_W-1:0]   bits_ff;
   logic [N_W-1:0]      n_ff;
   logic                last_ff;
   logic [N_W-1:0]      cnt_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [1:0]          phase_ff;
   logic [HET_W-1:0]    het_ff;
   logic [SQ_W-1:0]     sq_ff;
   logic [POLY_W-1:0]   poly_ff;
   logic [DEN_W-1:0]    denom_ff;
   logic [PI_W-1:0]     pi_ff;
   logic [TH_W-1:0]     th_ff;
   logic                rsp_tvalid_ff;
   logic [RSP_W-1:0]    rsp_tdata_ff;

   logic [N_W-1:0]      n_eff;
   logic [SITE_W-1:0]   site_mask;
   logic [PCNT_W-1:0]   chunk_ones;
   logic [N_W-1:0]      mul_a;
   logic [N_W-1:0]      mul_b;
   logic [PROD_W-1:0]   prod;
   logic [HET_W:0]      het_sum;
   logic [SQ_W:0]       sq_sum;
   logic [HET_W-1:0]    het_in;
   logic [SQ_W-1:0]     sq_in;
   logic [POLY_W-1:0]   poly_in;
   logic                out_free;
   logic                rsp_tvalid_in;
   logic [PI_W-1:0]     pi_in;
   logic [TH_W-1:0]     th_in;
   logic [DIFF_W-1:0]   diff_in;

   div_ctrl_type        div_ctrl;
   div_stat_type        div_stat;
   logic [DIV_W-1:0]    div_dividend;
   logic [DIV_W-1:0]    div_quotient;

   // Clamp the sample count and build the haplotype mask
   always_comb begin
      if (n_samples_ff < N_W'(MIN_SAMPLES))
         n_eff = N_W'(MIN_SAMPLES);
      else if (n_samples_ff > N_W'(MAX_SAMPLES))
         n_eff = N_W'(MAX_SAMPLES);
      else
         n_eff = n_samples_ff;
      if (n_eff >= N_W'(SITE_W))
         site_mask = '1;
      else
         site_mask = ~({SITE_W{1'b1}} << n_eff[N_W-2:0]);
   end

   // Count the ones in the low byte of the column
   always_comb begin
      chunk_ones = '0;
      for (int i = 0; i < CHUNK_W; i++)
         chunk_ones = chunk_ones + PCNT_W'(bits_ff[i]);
   end

   // Shared multiplier: operands follow the phase
   always_comb begin
      case (phase_ff)
         PH_HET: begin
            mul_a = cnt_ff;
            mul_b = n_ff - cnt_ff;
         end
         PH_SQ: begin
            mul_a = cnt_ff;
            mul_b = cnt_ff;
         end
         PH_DEN: begin
            mul_a = n_ff;
            mul_b = n_ff - 1'b1;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   // Saturating accumulation
   always_comb begin
      het_sum = {1'b0, het_ff} + (HET_W + 1)'(prod);
      sq_sum  = {1'b0, sq_ff} + (SQ_W + 1)'(prod);
      het_in  = het_sum[HET_W] ? '1 : het_sum[HET_W-1:0];
      sq_in   = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
      if ((cnt_ff != '0) && (cnt_ff < n_ff) && (poly_ff != '1))
         poly_in = poly_ff + 1'b1;
      else
         poly_in = poly_ff;
   end

   // Divider feed and estimator saturation
   always_comb begin
      div_ctrl.start = (state_ff == ST_START_HET) || (state_ff == ST_START_SQ);
      if (state_ff == ST_START_HET)
         div_dividend = {(DIV_W - HET_W - SCALE_SH)'(0), het_ff, SCALE_SH'(0)};
      else
         div_dividend = {sq_ff, SCALE_SH'(0)};
      pi_in   = (div_quotient[DIV_W-1:PI_W] != '0) ? '1 : div_quotient[PI_W-1:0];
      th_in   = (div_quotient[DIV_W-1:TH_W] != '0) ? '1 : div_quotient[TH_W-1:0];
      diff_in = {(DIFF_W - PI_W)'(0), pi_ff} - {(DIFF_W - TH_W)'(0), th_ff};
      out_free = !rsp_tvalid_ff || rsp_tready;
   end

   // Hold the result word until taken, raise it when a result is loaded
   always_comb begin
      rsp_tvalid_in = ((state_ff == ST_OUT) && out_free) || (rsp_tvalid_ff && !rsp_tready);
   end

   sda_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (denom_ff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // Sequencer, accumulators and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         n_samples_ff  <= N_W'(MIN_SAMPLES);
         het_ff        <= '0;
         sq_ff         <= '0;
         poly_ff       <= '0;
         phase_ff      <= PH_HET;
         step_ff       <= '0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (csr_wr_en)
            n_samples_ff <= csr_wr_data;
         rsp_tvalid_ff <= rsp_tvalid_in;

         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  bits_ff  <= req_tdata & site_mask;
                  n_ff     <= n_eff;
                  last_ff  <= req_tlast;
                  cnt_ff   <= '0;
                  step_ff  <= '0;
                  state_ff <= ST_COUNT;
               end
            end
            ST_COUNT: begin
               cnt_ff  <= cnt_ff + N_W'(chunk_ones);
               bits_ff <= bits_ff >> CHUNK_W;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(CHUNKS - 1)) begin
                  phase_ff <= PH_HET;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               case (phase_ff)
                  PH_HET: begin
                     het_ff   <= het_in;
                     phase_ff <= PH_SQ;
                  end
                  PH_SQ: begin
                     sq_ff   <= sq_in;
                     poly_ff <= poly_in;
                     if (last_ff) begin
                        phase_ff <= PH_DEN;
                     end else begin
                        phase_ff <= PH_HET;
                        state_ff <= ST_IDLE;
                     end
                  end
                  default: begin
                     denom_ff <= prod[DEN_W-1:0];
                     phase_ff <= PH_HET;
                     state_ff <= ST_START_HET;
                  end
               endcase
            end
            ST_START_HET: state_ff <= ST_WAIT_HET;
            ST_WAIT_HET: begin
               if (div_stat.done) begin
                  pi_ff    <= pi_in;
                  state_ff <= ST_START_SQ;
               end
            end
            ST_START_SQ: state_ff <= ST_WAIT_SQ;
            ST_WAIT_SQ: begin
               if (div_stat.done) begin
                  th_ff    <= th_in;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               // Hold until the output register is free, then load and clear
               if (out_free) begin
                  rsp_tdata_ff  <= {2'b00, poly_ff, diff_in, th_ff, pi_ff};
                  het_ff        <= '0;
                  sq_ff         <= '0;
                  poly_ff       <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The allele count never exceeds the sample count once counting is done
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> (cnt_ff <= n_ff))
      else $error("allele count above sample count");

   // The divider is idle whenever the block can take a site
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_stat.busy)
      else $error("divider busy while idle");

   // The het sum only grows between results
   a_het_monotonic: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_OUT) |=> (het_ff >= $past(het_ff)))
      else $error("het sum dropped without a result");

   // Loading a result clears all sums
   a_clear_on_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=>
      (het_ff == '0 && sq_ff == '0 && poly_ff == '0 && rsp_tvalid_ff))
      else $error("sums not cleared after result");

endmodule

>>> sim/site_diversity_accumulator_tb.sv
`timescale 1ns / 100ps
module site_diversity_accumulator_tb;
   import sda_pkg::*;

   localparam int SETTLE_CYCLES = 128;
   localparam int GAP_PCT       = 28;
   localparam int SITE_TARGET   = 1300;

   localparam longint unsigned HET_TOP  = (64'd1 << HET_W) - 64'd1;
   localparam longint unsigned SQ_TOP   = (64'd1 << SQ_W) - 64'd1;
   localparam longint unsigned POLY_TOP = (64'd1 << POLY_W) - 64'd1;
   localparam longint unsigned PI_TOP   = (64'd1 << PI_W) - 64'd1;
   localparam longint unsigned TH_TOP   = (64'd1 << TH_W) - 64'd1;

   typedef struct packed {
      logic [PI_W-1:0]   pi;
      logic [TH_W-1:0]   th;
      logic [DIFF_W-1:0] diff;
      logic [POLY_W-1:0] seg;
   } estimate_type;

   typedef enum logic {ROW_CFG, ROW_SITE} row_kind_type;

   typedef struct packed {
      row_kind_type     kind;
      logic [N_W-1:0]   n_value;
      logic [SITE_W-1:0] bits;
      logic             last;
      logic             typed;
      estimate_type     est;
   } stim_row_type;

   // Results that can be read straight off the formulas
   localparam estimate_type EST_NULL       = '{32'h0, 34'h0, 35'h0, 17'd0};
   localparam estimate_type EST_SINGLETON  = '{32'h1_0000, 34'h1_0000, 35'h0, 17'd1};
   localparam estimate_type EST_FIXED_PAIR = '{32'h0, 34'h4_0000, 35'h7_FFFC_0000, 17'd0};

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [N_W-1:0]    csr_wr_data;
   logic              req_tvalid;
   logic              req_tready;
   logic [63:0]       req_tdata;   // [63:0] site_bits
   logic              req_tlast;   // last_site
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;   // [31:0] pi_q16, [65:32] theta_h_q16,
                                   // [100:66] h_diff_q16, [117:101] seg_sites

   // Predictor state
   logic [N_W-1:0]    n_reg = 7'd2;
   longint unsigned   het_sum = 0;
   longint unsigned   square_sum = 0;
   longint unsigned   seg_count = 0;

   estimate_type      pending_est[$];
   int                err_count = 0;
   int                sites_sent = 0;
   bit                calm = 1'b0;

   // Directed sweep: reset value, clamps, extremes, bits above n, n changed mid-set
   stim_row_type stim_rows [26] = '{
      '{ROW_SITE, 7'd0,   64'h3,                   1'b1, 1'b1, EST_FIXED_PAIR},
      '{ROW_SITE, 7'd0,   64'h1,                   1'b1, 1'b1, EST_SINGLETON},
      '{ROW_SITE, 7'd0,   64'hFFFF_FFFF_FFFF_FFFC, 1'b1, 1'b1, EST_NULL},
      '{ROW_CFG,  7'd0,   64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h2,                   1'b1, 1'b1, EST_SINGLETON},
      '{ROW_CFG,  7'd1,   64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, EST_FIXED_PAIR},
      '{ROW_CFG,  7'd64,  64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h0,                   1'b1, 1'b1, EST_NULL},
      '{ROW_SITE, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h8000_0000_0000_0001, 1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'hFFFF_FFFF_0000_0000, 1'b1, 1'b0, EST_NULL},
      '{ROW_CFG,  7'd65,  64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h5555_5555_5555_5555, 1'b1, 1'b0, EST_NULL},
      '{ROW_CFG,  7'd127, 64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, EST_NULL},
      '{ROW_CFG,  7'd33,  64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h0000_0001_0000_0000, 1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h8000_0001_0000_0000, 1'b1, 1'b0, EST_NULL},
      '{ROW_CFG,  7'd3,   64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h7,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h2,                   1'b0, 1'b0, EST_NULL},
      '{ROW_CFG,  7'd64,  64'h0,                   1'b0, 1'b0, EST_NULL},
      '{ROW_SITE, 7'd0,   64'h0F0F_0F0F_0F0F_0F0F, 1'b1, 1'b0, EST_NULL}
   };

   site_diversity_accumulator u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Accumulate one site; on a last site return the estimates and clear the sums
   function automatic bit diversity_step(input logic [63:0] bits, input logic last,
                                         output estimate_type est);
      longint unsigned n;
      longint unsigned c;
      longint unsigned denom;
      longint unsigned q;
      logic [63:0]     mask;
      logic [63:0]     d;
      n = 64'(n_reg);
      if (n < MIN_SAMPLES) n = MIN_SAMPLES;
      if (n > MAX_SAMPLES) n = MAX_SAMPLES;
      mask = (n >= 64) ? '1 : (64'd1 << n) - 64'd1;
      c = 64'($countones(bits & mask));
      het_sum = het_sum + c * (n - c);
      if (het_sum > HET_TOP) het_sum = HET_TOP;
      square_sum = square_sum + c * c;
      if (square_sum > SQ_TOP) square_sum = SQ_TOP;
      if (c > 0 && c < n && seg_count < POLY_TOP) seg_count++;
      est = '0;
      if (!last) return 1'b0;
      denom = n * (n - 1);
      q = ((het_sum * 2) << 16) / denom;
      est.pi = PI_W'((q > PI_TOP) ? PI_TOP : q);
      q = ((square_sum * 2) << 16) / denom;
      est.th = TH_W'((q > TH_TOP) ? TH_TOP : q);
      d = {32'b0, est.pi} - {30'b0, est.th};
      est.diff = d[DIFF_W-1:0];
      est.seg = POLY_W'(seg_count);
      het_sum = 0;
      square_sum = 0;
      seg_count = 0;
      return 1'b1;
   endfunction

   // Site column of mixed shape: dense, sparse, empty, full, narrow
   function automatic logic [63:0] rand_site();
      logic [63:0] v;
      case ($urandom_range(6))
         0: v = {$urandom, $urandom};
         1: v = '0;
         2: v = '1;
         3: v = 64'd1 << $urandom_range(63);
         4: v = ~(64'd1 << $urandom_range(63));
         5: v = {$urandom, $urandom} & ((64'd1 << $urandom_range(1, 63)) - 64'd1);
         default: v = {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Offer one site word, idling at random first; predict on acceptance
   task automatic send_site(input logic [63:0] bits, input logic last, input bit typed,
                            input estimate_type typed_est);
      estimate_type est;
      while (!calm && $urandom_range(99) < GAP_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= bits;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sites_sent++;
      if (diversity_step(bits, last, est))
         pending_est.insert(pending_est.size(), typed ? typed_est : est);
   endtask

   // Write n_samples once the block has drained
   task automatic write_samples(input logic [N_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_est.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_reg = value;
   endtask

   // Pile up large sums at n = 64, then close the set at n = 2 so the estimates saturate
   task automatic overflow_set(input bit dense);
      logic [63:0] bits;
      write_samples(7'd64);
      repeat (100) begin
         if (dense) begin
            bits = '1;
            repeat (3) bits[$urandom_range(63)] = 1'b0;
         end else begin
            bits = {$urandom, $urandom};
         end
         send_site(bits, 1'b0, 1'b0, EST_NULL);
      end
      write_samples(7'($urandom_range(0, 2)));
      send_site(rand_site(), 1'b1, 1'b0, EST_NULL);
   endtask

   // Result side: stall at random, check each accepted word against the oldest estimate
   initial begin
      estimate_type want;
      estimate_type got;
      forever begin
         rsp_tready <= calm || ($urandom_range(99) >= GAP_PCT);
         @(posedge clock);
         if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
            got.pi   = rsp_tdata[31:0];
            got.th   = rsp_tdata[65:32];
            got.diff = rsp_tdata[100:66];
            got.seg  = rsp_tdata[117:101];
            if (pending_est.size() == 0) begin
               $error("result word with no site set pending");
               err_count++;
            end else begin
               want = pending_est.pop_front();
               if (got.pi !== want.pi) begin
                  $error("pi_q16: expected %0h, got %0h", want.pi, got.pi);
                  err_count++;
               end
               if (got.th !== want.th) begin
                  $error("theta_h_q16: expected %0h, got %0h", want.th, got.th);
                  err_count++;
               end
               if (got.diff !== want.diff) begin
                  $error("h_diff_q16: expected %0h, got %0h", want.diff, got.diff);
                  err_count++;
               end
               if (got.seg !== want.seg) begin
                  $error("seg_sites: expected %0d, got %0d", want.seg, got.seg);
                  err_count++;
               end
            end
         end
      end
   end

   // Stimulus: directed table, then random phases of site sets
   initial begin
      int phase;
      int sets;
      int len;
      logic [N_W-1:0] n_pick;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CFG)
            write_samples(stim_rows[i].n_value);
         else
            send_site(stim_rows[i].bits, stim_rows[i].last, stim_rows[i].typed,
                      stim_rows[i].est);
      end

      phase = 0;
      while (sites_sent < SITE_TARGET) begin
         // hold both sides busy for a stretch in the middle of the run
         calm = (sites_sent >= 500 && sites_sent < 750);
         case ($urandom_range(9))
            0: n_pick = 7'd0;
            1: n_pick = 7'd1;
            2: n_pick = 7'd2;
            3: n_pick = 7'd64;
            4: n_pick = 7'd65;
            5: n_pick = 7'd127;
            6: n_pick = 7'($urandom_range(0, 127));
            default: n_pick = 7'($urandom_range(2, 64));
         endcase
         write_samples(n_pick);
         sets = $urandom_range(1, 6);
         repeat (sets) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
               send_site(rand_site(), k == len - 1, 1'b0, EST_NULL);
         end
         // leave a set open across the next register write now and then
         if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_site(rand_site(), 1'b0, 1'b0, EST_NULL);
         if (phase == 3 || phase == 9)
            overflow_set(phase == 3);
         phase++;
      end
      calm = 1'b0;
      send_site(rand_site(), 1'b1, 1'b0, EST_NULL);

      // drain, then allow for any stray word
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_est.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("site_diversity_accumulator test passed");
      else
         $display("site_diversity_accumulator test failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("site_diversity_accumulator test failed");
      $finish;
   end

endmodule

>>> sim.f
src/sda_pkg.sv
src/sda_divider.sv
src/site_diversity_accumulator.sv
sim/site_diversity_accumulator_tb.sv
